// ----- hdl/nec_ir_pulse_interval_decoder_assert.svh -----
// Assertion macros used by the checker file of the NEC IR decoder.
// No dependencies; included by bare file name.
`ifndef NEC_IR_PULSE_INTERVAL_DECODER_ASSERT_SVH
`define NEC_IR_PULSE_INTERVAL_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NIPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nipd assertion failed");

// Next-cycle implication, disabled during reset.
`define NIPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nipd assertion failed");

`endif

// ----- hdl/nipd_pkg.sv -----
// Package for the NEC IR pulse interval decoder: codes, widths, types.
// No dependencies.
`default_nettype none

package nipd_pkg;

    localparam int T_W       = 16;
    localparam int CODE_W    = 32;
    localparam int CNT_W     = 8;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 7;

    // queue depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RECV = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd6;

    localparam logic [T_W-1:0] RST_LEADER_MIN = 16'd12500;
    localparam logic [T_W-1:0] RST_LEADER_MAX = 16'd14000;
    localparam logic [T_W-1:0] RST_REPEAT_MIN = 16'd8500;
    localparam logic [T_W-1:0] RST_ONE_MIN    = 16'd2100;
    localparam logic [T_W-1:0] RST_ONE_MAX    = 16'd2350;
    localparam logic [T_W-1:0] RST_ZERO_MIN   = 16'd1000;
    localparam logic [T_W-1:0] RST_ZERO_MAX   = 16'd1220;

    // classified edge, as queued between front and back
    typedef struct packed {
        logic           op;
        logic           is_leader;
        logic           is_repeat;
        logic           is_one;
        logic           is_zero;
        logic           is_end;
        logic [T_W-1:0] interval;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ----- hdl/nipd_front.sv -----
// Front end: timing registers, input acceptance and interval classification.
// Depends on nipd_pkg.
`default_nettype none

module nipd_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [nipd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [nipd_pkg::T_W-1:0]        i_cfg_data,
    input  wire                            i_in_valid,
    input  wire                            i_operation,
    input  wire [nipd_pkg::T_W-1:0]        i_interval_us,
    input  wire nipd_pkg::t_q_stat         i_q_stat,
    output logic                           o_push,
    output nipd_pkg::t_item                o_item
);
    import nipd_pkg::*;

    logic [T_W-1:0] r_leader_min, r_leader_max, r_repeat_min;
    logic [T_W-1:0] r_one_min, r_one_max, r_zero_min, r_zero_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_min <= RST_LEADER_MIN;
            r_leader_max <= RST_LEADER_MAX;
            r_repeat_min <= RST_REPEAT_MIN;
            r_one_min    <= RST_ONE_MIN;
            r_one_max    <= RST_ONE_MAX;
            r_zero_min   <= RST_ZERO_MIN;
            r_zero_max   <= RST_ZERO_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_LEADER_MIN: r_leader_min <= i_cfg_data;
                REG_LEADER_MAX: r_leader_max <= i_cfg_data;
                REG_REPEAT_MIN: r_repeat_min <= i_cfg_data;
                REG_ONE_MIN:    r_one_min    <= i_cfg_data;
                REG_ONE_MAX:    r_one_max    <= i_cfg_data;
                REG_ZERO_MIN:   r_zero_min   <= i_cfg_data;
                REG_ZERO_MAX:   r_zero_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_push = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_item.op        = i_operation;
        o_item.interval  = i_interval_us;
        o_item.is_leader = (i_interval_us > r_leader_min) && (i_interval_us < r_leader_max);
        o_item.is_repeat = (i_interval_us > r_repeat_min) && (i_interval_us <= r_leader_min);
        o_item.is_one    = (i_interval_us > r_one_min) && (i_interval_us < r_one_max);
        o_item.is_zero   = (i_interval_us > r_zero_min) && (i_interval_us < r_zero_max);
        o_item.is_end    = (i_interval_us >= r_leader_max);
    end

endmodule

`default_nettype wire

// ----- hdl/nipd_queue.sv -----
// Short FIFO of classified edges between front and back end.
// Depends on nipd_pkg.
`default_nettype none

module nipd_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire nipd_pkg::t_item    i_item,
    input  wire                     i_pop,
    output nipd_pkg::t_item         o_item,
    output nipd_pkg::t_q_stat       o_stat
);
    import nipd_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_stat.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/nipd_back.sv -----
// Back end: decode state machine; its state registers are the result register.
// Depends on nipd_pkg.
`default_nettype none

module nipd_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire nipd_pkg::t_q_stat         i_q_stat,
    input  wire nipd_pkg::t_item           i_item,
    output logic                           o_pop,
    input  wire                            i_out_stall,
    output logic                           o_out_valid,
    output logic [nipd_pkg::PHASE_W-1:0]   o_phase,
    output logic [nipd_pkg::CODE_W-1:0]    o_code_word,
    output logic [nipd_pkg::CNT_W-1:0]     o_bits_received,
    output logic [nipd_pkg::CNT_W-1:0]     o_repeats_seen,
    output logic [nipd_pkg::T_W-1:0]       o_repeat_interval
);
    import nipd_pkg::*;

    logic               r_out_valid;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [CNT_W-1:0]   r_bits, n_bits;
    logic [CNT_W-1:0]   r_reps, n_reps;
    logic [T_W-1:0]     r_rep_t, n_rep_t;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_bits  = r_bits;
        n_reps  = r_reps;
        n_rep_t = r_rep_t;
        if (i_item.op == OP_CLEAR) begin
            n_phase = PH_IDLE;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_item.is_leader) begin
                        n_code  = '0;
                        n_bits  = '0;
                        n_reps  = '0;
                        n_phase = PH_RECV;
                    end else if (i_item.is_repeat) begin
                        n_rep_t = i_item.interval;
                        n_reps  = r_reps + 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_RECV: begin
                    if (i_item.is_one || i_item.is_zero) begin
                        n_code = {r_code[CODE_W-2:0], i_item.is_one};
                        n_bits = r_bits + 1'b1;
                    end else if (i_item.is_end) begin
                        n_phase = PH_DONE;
                        n_reps  = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_code      <= '0;
            r_bits      <= '0;
            r_reps      <= '0;
            r_rep_t     <= '0;
        end else begin
            r_out_valid <= o_pop || (r_out_valid && i_out_stall);
            if (o_pop) begin
                r_phase <= n_phase;
                r_code  <= n_code;
                r_bits  <= n_bits;
                r_reps  <= n_reps;
                r_rep_t <= n_rep_t;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_phase           = r_phase;
    assign o_code_word       = r_code;
    assign o_bits_received   = r_bits;
    assign o_repeats_seen    = r_reps;
    assign o_repeat_interval = r_rep_t;

endmodule

`default_nettype wire

// ----- hdl/nec_ir_pulse_interval_decoder.sv -----
// Top level of the NEC IR pulse interval decoder: front, queue and back end.
// Depends on nipd_pkg, nipd_front, nipd_queue, nipd_back.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_operation, i_interval_us
//  result    out        o_out_valid / i_out_stall  o_phase, o_code_word, o_bits_received,
//                                                  o_repeats_seen, o_repeat_interval
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while the result side does not stall. An accepted
// input is written into the queue, then into the state registers when it is popped.
// The two-entry queue absorbs a stalled result side; input stalls once it holds two.
// Synchronous active-low reset; no clearing pass, the block is ready right after.
`default_nettype none

module nec_ir_pulse_interval_decoder (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [nipd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [nipd_pkg::T_W-1:0]        i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_operation,
    input  wire [nipd_pkg::T_W-1:0]        i_interval_us,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [nipd_pkg::PHASE_W-1:0]   o_phase,
    output logic [nipd_pkg::CODE_W-1:0]    o_code_word,
    output logic [nipd_pkg::CNT_W-1:0]     o_bits_received,
    output logic [nipd_pkg::CNT_W-1:0]     o_repeats_seen,
    output logic [nipd_pkg::T_W-1:0]       o_repeat_interval
);
    import nipd_pkg::*;

    logic    push, pop;
    t_item   front_item, queue_item;
    t_q_stat q_stat;

    assign o_in_stall = q_stat.full;

    nipd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_operation   (i_operation),
        .i_interval_us (i_interval_us),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_item        (front_item)
    );

    nipd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_stat  (q_stat)
    );

    nipd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_stat          (q_stat),
        .i_item            (queue_item),
        .o_pop             (pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_phase           (o_phase),
        .o_code_word       (o_code_word),
        .o_bits_received   (o_bits_received),
        .o_repeats_seen    (o_repeats_seen),
        .o_repeat_interval (o_repeat_interval)
    );

endmodule

`default_nettype wire

// ----- hdl/nipd_checker.sv -----
// Port-level checker for the NEC IR decoder, bound to the top level.
// Depends on nipd_pkg and nec_ir_pulse_interval_decoder_assert.svh.
`default_nettype none
`include "nec_ir_pulse_interval_decoder_assert.svh"

module nipd_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_out_valid,
    input wire                            i_out_stall,
    input wire [nipd_pkg::PHASE_W-1:0]    o_phase,
    input wire [nipd_pkg::CODE_W-1:0]     o_code_word,
    input wire [nipd_pkg::CNT_W-1:0]      o_bits_received,
    input wire [nipd_pkg::CNT_W-1:0]      o_repeats_seen,
    input wire [nipd_pkg::T_W-1:0]        o_repeat_interval
);
    import nipd_pkg::*;

    logic                                   out_xact;
    logic [PHASE_W+CODE_W+2*CNT_W+T_W-1:0]  out_payload;

    assign out_xact    = o_out_valid && !i_out_stall;
    assign out_payload = {o_phase, o_code_word, o_bits_received, o_repeats_seen,
                          o_repeat_interval};

    `NIPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(out_payload))
    `NIPD_ASSERT_IMPLY(a_rst_no_out, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)
    `NIPD_ASSERT_IMPLY(a_no_done_to_recv, i_clk, i_rst_n,
        out_xact && $past(out_xact) && (o_phase == PH_RECV), $past(o_phase) != PH_DONE)
    `NIPD_ASSERT_IMPLY(a_bits_step, i_clk, i_rst_n, out_xact && $past(out_xact),
        (o_bits_received - $past(o_bits_received) <= 8'd1) || (o_bits_received == 8'd0))

endmodule

bind nec_ir_pulse_interval_decoder nipd_checker u_nipd_checker (.*);

`default_nettype wire

// ----- bench/nec_ir_pulse_interval_decoder_tb.sv -----
// Self-checking bench for nec_ir_pulse_interval_decoder: random NEC frames, repeats and
// noise under several register settings, checked against an in-bench decoder model.
// Depends on nipd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module nec_ir_pulse_interval_decoder_tb;
    import nipd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 160;

    typedef struct packed {
        logic           op;
        logic [T_W-1:0] interval;
    } t_ir_edge;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CODE_W-1:0]  code;
        logic [CNT_W-1:0]   bit_count;
        logic [CNT_W-1:0]   repeat_count;
        logic [T_W-1:0]     repeat_us;
    } t_decode_state;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [T_W-1:0]       cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 op_drv = OP_EDGE;
    logic [T_W-1:0]       interval_drv = '0;
    logic                 out_stall = 1'b0;

    wire                  cfg_ready;
    wire                  in_stall;
    wire                  out_valid;
    wire [PHASE_W-1:0]    phase_out;
    wire [CODE_W-1:0]     code_out;
    wire [CNT_W-1:0]      bits_out;
    wire [CNT_W-1:0]      repeats_out;
    wire [T_W-1:0]        repeat_us_out;

    nec_ir_pulse_interval_decoder i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (op_drv),
        .i_interval_us     (interval_drv),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_phase           (phase_out),
        .o_code_word       (code_out),
        .o_bits_received   (bits_out),
        .o_repeats_seen    (repeats_out),
        .o_repeat_interval (repeat_us_out)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // decoder model state and register copy
    logic [T_W-1:0] cfg_regs [NUM_REGS];
    t_decode_state  model;

    t_ir_edge       pending_edges [$];
    t_decode_state  expected_states [$];
    t_ir_edge       cur_edge;

    bit          calm_in = 1'b0;
    bit          calm_out = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_gap = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count = 0;
    int unsigned edges_sent = 0;
    int unsigned results_checked = 0;
    int unsigned items_added = 0;
    int unsigned frames_queued = 0;
    int unsigned repeats_queued = 0;
    int unsigned settings_loaded = 0;

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic reset_model();
        cfg_regs[REG_LEADER_MIN] = RST_LEADER_MIN;
        cfg_regs[REG_LEADER_MAX] = RST_LEADER_MAX;
        cfg_regs[REG_REPEAT_MIN] = RST_REPEAT_MIN;
        cfg_regs[REG_ONE_MIN]    = RST_ONE_MIN;
        cfg_regs[REG_ONE_MAX]    = RST_ONE_MAX;
        cfg_regs[REG_ZERO_MIN]   = RST_ZERO_MIN;
        cfg_regs[REG_ZERO_MAX]   = RST_ZERO_MAX;
        model = '{phase: PH_IDLE, default: '0};
    endtask

    task automatic decode_edge(input t_ir_edge e);
        logic [T_W-1:0] t;
        t = e.interval;
        if (e.op == OP_CLEAR) begin
            model.phase = PH_IDLE;
        end else if (model.phase == PH_IDLE) begin
            if (t > cfg_regs[REG_LEADER_MIN] && t < cfg_regs[REG_LEADER_MAX]) begin
                model.code = '0;
                model.bit_count = '0;
                model.repeat_count = '0;
                model.phase = PH_RECV;
            end else if (t > cfg_regs[REG_REPEAT_MIN] && t <= cfg_regs[REG_LEADER_MIN]) begin
                model.repeat_us = t;
                model.repeat_count = model.repeat_count + 1'b1;
                model.phase = PH_DONE;
            end
        end else if (model.phase == PH_RECV) begin
            if (t > cfg_regs[REG_ONE_MIN] && t < cfg_regs[REG_ONE_MAX]) begin
                model.code = {model.code[CODE_W-2:0], 1'b1};
                model.bit_count = model.bit_count + 1'b1;
            end else if (t > cfg_regs[REG_ZERO_MIN] && t < cfg_regs[REG_ZERO_MAX]) begin
                model.code = {model.code[CODE_W-2:0], 1'b0};
                model.bit_count = model.bit_count + 1'b1;
            end else if (t >= cfg_regs[REG_LEADER_MAX]) begin
                model.phase = PH_DONE;
                model.repeat_count = '0;
            end
        end
        expected_states.push_back(model);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 results_checked, what, got, want);
        error_count++;
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_edge(cur_edge);
                edges_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_edges.size() > 0) begin
                    cur_edge = pending_edges.pop_front();
                    op_drv <= cur_edge.op;
                    interval_drv <= cur_edge.interval;
                    in_valid <= 1'b1;
                    in_gap = pick_gap(calm_in);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and stall generator
    always @(posedge clk) begin
        t_decode_state want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_states.size() == 0) begin
                    report_mismatch("unexpected transaction", 32'd0, 32'd0);
                end else begin
                    want = expected_states.pop_front();
                    if (phase_out !== want.phase)
                        report_mismatch("phase", 32'(phase_out), 32'(want.phase));
                    if (code_out !== want.code)
                        report_mismatch("code_word", code_out, want.code);
                    if (bits_out !== want.bit_count)
                        report_mismatch("bits_received", 32'(bits_out),
                                        32'(want.bit_count));
                    if (repeats_out !== want.repeat_count)
                        report_mismatch("repeats_seen", 32'(repeats_out),
                                        32'(want.repeat_count));
                    if (repeat_us_out !== want.repeat_us)
                        report_mismatch("repeat_interval", 32'(repeat_us_out),
                                        32'(want.repeat_us));
                end
                results_checked++;
                if (results_checked == 200 || results_checked == 1100)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (out_gap > 0) begin
                out_stall <= 1'b1;
                out_gap--;
            end else begin
                out_stall <= 1'b0;
                out_gap = pick_gap(calm_out);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic add_item(input logic op, input logic [T_W-1:0] t);
        pending_edges.push_back('{op: op, interval: t});
        items_added++;
    endtask

    // value strictly inside (lo, hi), or anything when the window is empty
    function automatic logic [T_W-1:0] inside_window(input int lo, input int hi);
        if (hi - lo >= 2)
            return T_W'($urandom_range(hi - 1, lo + 1));
        return T_W'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [T_W-1:0] near_bound();
        logic [T_W-1:0] v;
        v = cfg_regs[$urandom_range(NUM_REGS - 1)];
        return v + T_W'($urandom_range(2)) - 1'b1;
    endfunction

    task automatic queue_frame();
        int unsigned nbits;
        int unsigned r;
        frames_queued++;
        if ($urandom_range(9) < 8)
            add_item(OP_CLEAR, T_W'($urandom_range(16'hFFFF)));
        add_item(OP_EDGE, inside_window(int'(cfg_regs[REG_LEADER_MIN]),
                                        int'(cfg_regs[REG_LEADER_MAX])));
        r = $urandom_range(99);
        if (r < 80)
            nbits = 32;
        else if (r < 97)
            nbits = $urandom_range(40);
        else
            nbits = $urandom_range(300, 250);
        for (int unsigned i = 0; i < nbits; i++) begin
            r = $urandom_range(99);
            if (r < 45)
                add_item(OP_EDGE, inside_window(int'(cfg_regs[REG_ONE_MIN]),
                                                int'(cfg_regs[REG_ONE_MAX])));
            else if (r < 90)
                add_item(OP_EDGE, inside_window(int'(cfg_regs[REG_ZERO_MIN]),
                                                int'(cfg_regs[REG_ZERO_MAX])));
            else if (r < 95)
                add_item(OP_EDGE, near_bound());
            else
                add_item(OP_EDGE, T_W'($urandom_range(16'hFFFF)));
        end
        if ($urandom_range(99) < 85)
            add_item(OP_EDGE, T_W'($urandom_range(16'hFFFF, cfg_regs[REG_LEADER_MAX])));
        repeat ($urandom_range(2))
            add_item(OP_EDGE, T_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic queue_repeat();
        repeats_queued++;
        add_item(OP_CLEAR, T_W'($urandom_range(16'hFFFF)));
        add_item(OP_EDGE,
                 inside_window(int'(cfg_regs[REG_REPEAT_MIN]),
                               int'(cfg_regs[REG_LEADER_MIN]) + 1));
        repeat ($urandom_range(2))
            add_item(OP_EDGE, T_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(5, 1)) begin
            add_item($urandom_range(9) == 0 ? OP_CLEAR : OP_EDGE,
                     $urandom_range(1) ? near_bound() : 16'($urandom_range(16'hFFFF)));
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_edges.size() > 0 || in_valid || expected_states.size() > 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [T_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
            cfg_regs[idx] = data;
    endtask

    task automatic load_setting(input logic [T_W-1:0] lmin, lmax, rmin, omin, omax,
                                zmin, zmax);
        write_reg(REG_LEADER_MIN, lmin);
        write_reg(REG_LEADER_MAX, lmax);
        write_reg(REG_REPEAT_MIN, rmin);
        write_reg(REG_ONE_MIN, omin);
        write_reg(REG_ONE_MAX, omax);
        write_reg(REG_ZERO_MIN, zmin);
        write_reg(REG_ZERO_MAX, zmax);
        settings_loaded++;
    endtask

    task automatic run_random(input int unsigned n, input bit quiet_in, input bit quiet_out);
        int unsigned goal;
        int unsigned r;
        @(negedge clk);
        calm_in = quiet_in;
        calm_out = quiet_out;
        goal = items_added + n;
        while (items_added < goal) begin
            r = $urandom_range(99);
            if (r < 60)
                queue_frame();
            else if (r < 80)
                queue_repeat();
            else
                queue_noise();
        end
        wait_drained();
    endtask

    initial begin
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default windows: boundaries, repeat, frame end, clears and ignored edges
        @(negedge clk);
        add_item(OP_EDGE, 16'd0);
        add_item(OP_EDGE, 16'hFFFF);
        add_item(OP_EDGE, 16'd8501);
        add_item(OP_EDGE, 16'd12600);
        add_item(OP_CLEAR, 16'hFFFF);
        add_item(OP_EDGE, 16'd12500);
        add_item(OP_CLEAR, 16'd0);
        add_item(OP_EDGE, 16'd8500);
        add_item(OP_EDGE, 16'd12501);
        add_item(OP_EDGE, 16'd2101);
        add_item(OP_EDGE, 16'd2349);
        add_item(OP_EDGE, 16'd1001);
        add_item(OP_EDGE, 16'd1219);
        add_item(OP_EDGE, 16'd2100);
        add_item(OP_EDGE, 16'd2350);
        add_item(OP_EDGE, 16'd1000);
        add_item(OP_EDGE, 16'd1220);
        add_item(OP_EDGE, 16'd13999);
        add_item(OP_EDGE, 16'd14000);
        add_item(OP_CLEAR, 16'd0);
        add_item(OP_EDGE, 16'd13999);
        add_item(OP_EDGE, 16'hFFFF);
        add_item(OP_CLEAR, 16'h5A5A);
        add_item(OP_EDGE, 16'd14000);
        add_item(OP_EDGE, 16'd12500);
        wait_drained();

        run_random(450, 1'b0, 1'b0);

        // overlapping windows: leader beats repeat, one beats zero beats frame end
        load_setting(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        run_random(300, 1'b0, 1'b1);

        load_setting(16'd20000, 16'd30000, 16'd15000, 16'd3000, 16'd4000, 16'd500, 16'd900);
        run_random(400, 1'b1, 1'b0);

        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(60, 1'b0, 1'b0);

        load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(60, 1'b0, 1'b0);

        // one-value windows: the one-bit window at the bottom, the others at the top of the range
        load_setting(16'd65533, 16'hFFFF, 16'd65532, 16'd0, 16'd2, 16'd65533, 16'hFFFF);
        run_random(250, 1'b1, 1'b1);

        write_reg(REG_NONE, 16'hFFFF);
        load_setting(RST_LEADER_MIN, RST_LEADER_MAX, RST_REPEAT_MIN, RST_ONE_MIN,
                     RST_ONE_MAX, RST_ZERO_MIN, RST_ZERO_MAX);
        run_random(430, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        $display("Sent %0d edge transactions (%0d frames, %0d repeat codes) over %0d settings;",
                 edges_sent, frames_queued, repeats_queued, settings_loaded + 1);
        $display("checked %0d decoder results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0 && expected_states.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- nec_ir_pulse_interval_decoder.f -----
+incdir+hdl
hdl/nipd_pkg.sv
hdl/nipd_front.sv
hdl/nipd_queue.sv
hdl/nipd_back.sv
hdl/nec_ir_pulse_interval_decoder.sv
hdl/nipd_checker.sv
bench/nec_ir_pulse_interval_decoder_tb.sv
